[hw/rtl/stc_pkg.sv]
// stc_pkg: constants, command and register codes and the split-row helper
// shared by the sprite tile compositor modules
// no dependencies
package stc_pkg;

  localparam int unsigned TILE_SIDE = 32;
  localparam int unsigned NPIX      = TILE_SIDE * TILE_SIDE;
  localparam int unsigned COORD_W   = $clog2(TILE_SIDE);
  localparam int unsigned PIX_W     = $clog2(NPIX);
  localparam int unsigned RGB_W     = 24;

  localparam logic [RGB_W-1:0] KEY_RGB  = 24'h476c6c;
  localparam logic [RGB_W-1:0] BAND_RGB = 24'h200000;

  // commands
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_COMPOSE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // configuration register indexes
  localparam logic CFG_CORPSE = 1'b0;
  localparam logic CFG_MESH   = 1'b1;

  // mesh modes
  localparam logic [1:0] MESH_CHECKER = 2'd1;
  localparam logic [1:0] MESH_DOTS    = 2'd2;

  // split row boundaries and rows
  localparam logic [COORD_W-1:0] SPLIT_X_OUTER_LO = 5'd4;
  localparam logic [COORD_W-1:0] SPLIT_X_OUTER_HI = 5'd28;
  localparam logic [COORD_W-1:0] SPLIT_X_INNER_LO = 5'd12;
  localparam logic [COORD_W-1:0] SPLIT_X_INNER_HI = 5'd20;
  localparam logic [COORD_W-1:0] SPLIT_ROW_OUTER  = 5'd20;
  localparam logic [COORD_W-1:0] SPLIT_ROW_MID    = 5'd19;
  localparam logic [COORD_W-1:0] SPLIT_ROW_INNER  = 5'd18;
  localparam logic [COORD_W-1:0] CENTRE           = 5'd16;

  function automatic logic [COORD_W-1:0] split_row(input logic [COORD_W-1:0] x);
    logic [COORD_W-1:0] r;
    if (x < SPLIT_X_OUTER_LO || x >= SPLIT_X_OUTER_HI) r = SPLIT_ROW_OUTER;
    else if (x < SPLIT_X_INNER_LO || x >= SPLIT_X_INNER_HI) r = SPLIT_ROW_MID;
    else r = SPLIT_ROW_INNER;
    return r;
  endfunction

endpackage

[hw/rtl/stc_if.sv]
// stc_cmd_if and stc_res_if: valid/ready channels of the compositor
// no dependencies
interface stc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [9:0] pixel_index;
  logic [7:0] sprite_red;
  logic [7:0] sprite_green;
  logic [7:0] sprite_blue;
  logic [7:0] floor_red;
  logic [7:0] floor_green;
  logic [7:0] floor_blue;

  modport source (
    output valid, func, pixel_index, sprite_red, sprite_green, sprite_blue,
           floor_red, floor_green, floor_blue,
    input  ready
  );
  modport sink (
    input  valid, func, pixel_index, sprite_red, sprite_green, sprite_blue,
           floor_red, floor_green, floor_blue,
    output ready
  );
endinterface

interface stc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

[hw/rtl/sprite_tile_compositor.sv]
// sprite_tile_compositor: composites a 32x32 sprite over a floor tile
// depends on stc_pkg, stc_if, stc_ram, stc_src_map
//
// A load item writes one sprite pixel and one floor pixel (the floor pixel is
// the starting destination value). A read item returns the destination pixel
// through a registered output with a one-entry skid, so loads keep flowing
// while a single result waits. A compose item runs the whole tile from
// memory: a first pass over all 1024 pixels and a drain state, reading the
// sprite ram at the mapped source pixel and writing the destination ram and a
// 32x32 drawn-flag ram kept as one word per row. In corpse mode a second pass
// follows row by row (row read, capture, then a write per pixel) that fills
// the split band and writes the diagonal shadows. The single write port of
// the destination ram sets the pace of both passes. No item is accepted while
// a compose runs. Sprite and destination pixels read before being written
// hold no defined value.
module sprite_tile_compositor import stc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  stc_cmd_if.sink       cmd,
  stc_res_if.source     res,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [1:0]    cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_P1     = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_P2_RD  = 3'd3;
  localparam logic [2:0] ST_P2_CAP = 3'd4;
  localparam logic [2:0] ST_P2_WR  = 3'd5;

  // config
  logic       corpse_mode;
  logic [1:0] mesh_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      corpse_mode <= 1'b0;
      mesh_mode   <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CORPSE: corpse_mode <= cfg_data[0];
        CFG_MESH:   mesh_mode   <= cfg_data;
        default:    ;
      endcase
    end
  end

  logic [2:0] state;
  logic [PIX_W-1:0] cnt;

  // handshake and command decode
  logic rd_pend, out_vld, skid_vld;
  logic cmd_acc, take;
  logic [RGB_W-1:0] sprite_px, floor_px;

  assign cmd.ready = (state == ST_IDLE) && !skid_vld && !(rd_pend && out_vld);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign take      = res.valid && res.ready;
  assign sprite_px = {cmd.sprite_red, cmd.sprite_green, cmd.sprite_blue};
  assign floor_px  = {cmd.floor_red, cmd.floor_green, cmd.floor_blue};

  // opaque bounding box
  logic [COORD_W-1:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic [COORD_W-1:0] ld_x, ld_y;
  logic [COORD_W:0]   sum_x, sum_y;
  logic signed [5:0]  ox, oy;

  assign ld_x  = cmd.pixel_index[COORD_W-1:0];
  assign ld_y  = cmd.pixel_index[PIX_W-1:COORD_W];
  assign sum_x = {1'b0, box_max_x} + {1'b0, box_min_x};
  assign sum_y = {1'b0, box_max_y} + {1'b0, box_min_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= 5'd31;
      box_max_x <= 5'd0;
      box_min_y <= 5'd31;
      box_max_y <= 5'd0;
    end else if (cmd_acc && cmd.func == CMD_LOAD) begin
      if (sprite_px != KEY_RGB && sprite_px != '0) begin
        if (ld_x < box_min_x) box_min_x <= ld_x;
        if (ld_x > box_max_x) box_max_x <= ld_x;
        if (ld_y < box_min_y) box_min_y <= ld_y;
        if (ld_y > box_max_y) box_max_y <= ld_y;
      end
    end else if (cmd_acc && cmd.func == CMD_COMPOSE) begin
      // box is spent once the centring offsets are taken
      box_min_x <= 5'd31;
      box_max_x <= 5'd0;
      box_min_y <= 5'd31;
      box_max_y <= 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_acc && cmd.func == CMD_COMPOSE) begin
      ox <= $signed({1'b0, sum_x[COORD_W:1]}) - $signed({1'b0, CENTRE});
      oy <= $signed({1'b0, sum_y[COORD_W:1]}) - $signed({1'b0, CENTRE});
    end
  end

  // source mapping for the first pass
  logic               map_skip;
  logic [PIX_W-1:0]   map_src;

  stc_src_map u_map (
    .corpse (corpse_mode),
    .x      (cnt[COORD_W-1:0]),
    .y      (cnt[PIX_W-1:COORD_W]),
    .ox     (ox),
    .oy     (oy),
    .skip   (map_skip),
    .src    (map_src)
  );

  // sprite store
  logic [RGB_W-1:0] spr_rdata;

  stc_ram #(.WIDTH(RGB_W), .DEPTH(NPIX)) u_sprite (
    .clk   (clk),
    .we    (cmd_acc && cmd.func == CMD_LOAD),
    .waddr (cmd.pixel_index),
    .wdata (sprite_px),
    .raddr (map_src),
    .rdata (spr_rdata)
  );

  // first pass, second stage: colour decision and writes
  logic               s2_vld, s2_skip;
  logic [COORD_W-1:0] s2_x, s2_y;
  logic [RGB_W-1:0]   dd;
  logic               draw;
  logic [TILE_SIDE-1:0] row_acc, row_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= (state == ST_P1);
    end
  end

  always_ff @(posedge clk) begin
    s2_x    <= cnt[COORD_W-1:0];
    s2_y    <= cnt[PIX_W-1:COORD_W];
    s2_skip <= map_skip;
  end

  always_comb begin
    dd = spr_rdata;
    if (mesh_mode == MESH_DOTS && dd != KEY_RGB && !(s2_x[0] ^ s2_y[0])) dd = '0;
    if (mesh_mode == MESH_CHECKER && (s2_x[1] ^ s2_y[1])) dd = '0;
    draw = !s2_skip && dd != KEY_RGB && !(corpse_mode && dd == '0);
    row_word = row_acc;
    row_word[s2_x] = draw;
  end

  always_ff @(posedge clk) begin
    if (s2_vld) row_acc <= row_word;
  end

  // rows 16 to 21 kept for the split band
  logic [TILE_SIDE-1:0] cap [6];
  logic [TILE_SIDE-1:0] band_cols, band_cols_c;

  always_ff @(posedge clk) begin
    if (s2_vld && s2_x == 5'd31 && s2_y >= 5'd16 && s2_y <= 5'd21) begin
      cap[3'(s2_y - 5'd16)] <= row_word;
    end
  end

  always_comb begin
    logic [COORD_W-1:0] cy;
    for (int x = 0; x < TILE_SIDE; x++) begin
      cy = split_row(5'(x));
      band_cols_c[x] = cap[3'(cy - 5'd18)][x] && cap[3'(cy - 5'd15)][x];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) band_cols <= band_cols_c;
  end

  function automatic logic [TILE_SIDE-1:0] band_row(input logic [COORD_W-1:0] y,
                                                    input logic [TILE_SIDE-1:0] cols);
    logic [TILE_SIDE-1:0] r;
    logic [COORD_W-1:0]   cy;
    for (int x = 0; x < TILE_SIDE; x++) begin
      cy = split_row(5'(x));
      r[x] = cols[x] && (y == cy - 5'd1 || y == cy);
    end
    return r;
  endfunction

  // drawn flags, one word per row
  logic [TILE_SIDE-1:0] drw_rdata;

  stc_ram #(.WIDTH(TILE_SIDE), .DEPTH(TILE_SIDE)) u_drawn (
    .clk   (clk),
    .we    (s2_vld && s2_x == 5'd31),
    .waddr (s2_y),
    .wdata (row_word),
    .raddr (cnt[PIX_W-1:COORD_W]),
    .rdata (drw_rdata)
  );

  // second pass: current row and the three above it
  logic [TILE_SIDE-1:0] r0, r1, r2, r3, bmask, cur_band, shadow;

  assign cur_band = band_row(cnt[PIX_W-1:COORD_W], band_cols);
  // direct diagonal neighbour, or the longer tail two and three steps back
  assign shadow = ~r0 & ((r1 << 1) | (~(r1 << 1) & (r2 << 2) & (r3 << 3)));

  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) begin
      r0 <= '0;
      r1 <= '0;
      r2 <= '0;
      r3 <= '0;
    end else if (state == ST_P2_CAP) begin
      r0    <= drw_rdata | cur_band;
      r1    <= r0;
      r2    <= r1;
      r3    <= r2;
      bmask <= cur_band;
    end
  end

  // destination store write selection
  logic               dst_we;
  logic [PIX_W-1:0]   dst_waddr;
  logic [RGB_W-1:0]   dst_wdata, dst_rdata;

  always_comb begin
    dst_we    = 1'b0;
    dst_waddr = cmd.pixel_index;
    dst_wdata = floor_px;
    if (cmd_acc && cmd.func == CMD_LOAD) begin
      dst_we = 1'b1;
    end else if (s2_vld) begin
      dst_we    = draw;
      dst_waddr = {s2_y, s2_x};
      dst_wdata = dd;
    end else if (state == ST_P2_WR) begin
      dst_waddr = cnt;
      if (bmask[cnt[COORD_W-1:0]]) begin
        dst_we    = 1'b1;
        dst_wdata = BAND_RGB;
      end else if (shadow[cnt[COORD_W-1:0]]) begin
        dst_we    = 1'b1;
        dst_wdata = '0;
      end
    end
  end

  stc_ram #(.WIDTH(RGB_W), .DEPTH(NPIX)) u_dest (
    .clk   (clk),
    .we    (dst_we),
    .waddr (dst_waddr),
    .wdata (dst_wdata),
    .raddr (cmd.pixel_index),
    .rdata (dst_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (cmd_acc && cmd.func == CMD_COMPOSE) state <= ST_P1;
        end
        ST_P1: begin
          cnt <= cnt + 1'b1;
          if (cnt == PIX_W'(NPIX - 1)) state <= ST_DRAIN;
        end
        ST_DRAIN: begin
          cnt   <= '0;
          state <= corpse_mode ? ST_P2_RD : ST_IDLE;
        end
        ST_P2_RD:  state <= ST_P2_CAP;
        ST_P2_CAP: state <= ST_P2_WR;
        ST_P2_WR: begin
          cnt <= cnt + 1'b1;
          if (cnt == PIX_W'(NPIX - 1)) state <= ST_IDLE;
          else if (cnt[COORD_W-1:0] == 5'd31) state <= ST_P2_RD;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register with a one-entry skid
  logic [RGB_W-1:0] out_px, skid_px;

  // a fresh read never meets a full skid, the input is held off first
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend  <= 1'b0;
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      rd_pend <= cmd_acc && cmd.func == CMD_READ;
      if (rd_pend) begin
        out_vld <= 1'b1;
        if (out_vld && !take) skid_vld <= 1'b1;
      end else if (take) begin
        if (skid_vld) begin
          skid_vld <= 1'b0;
        end else begin
          out_vld <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_vld) out_px <= skid_px;
    if (rd_pend) begin
      if (!out_vld || (take && !skid_vld)) out_px <= dst_rdata;
      else skid_px <= dst_rdata;
    end
  end

  assign res.valid     = out_vld;
  assign res.out_red   = out_px[23:16];
  assign res.out_green = out_px[15:8];
  assign res.out_blue  = out_px[7:0];

endmodule

[hw/rtl/stc_ram.sv]
// stc_ram: generic single write, single read port ram, registered read
// no dependencies
module stc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/stc_src_map.sv]
// stc_src_map: maps a destination pixel to its sprite source pixel
// depends on stc_pkg (split_row, widths)
module stc_src_map import stc_pkg::*; (
  input  logic                corpse,
  input  logic [COORD_W-1:0]  x,
  input  logic [COORD_W-1:0]  y,
  input  logic signed [5:0]   ox,
  input  logic signed [5:0]   oy,
  output logic                skip,
  output logic [PIX_W-1:0]    src
);

  logic [COORD_W-1:0] cy;
  logic signed [7:0]  yo, y1a, t, q, x1a, y1b, x1b, cye;
  logic               in_band, oob;

  always_comb begin
    cy      = split_row(x);
    in_band = (y == cy - 5'd1) || (y == cy);
    cye     = $signed({3'b000, cy});
    yo      = $signed({3'b000, y}) + $signed({{2{oy[5]}}, oy});
    y1a     = (yo <<< 1) - 8'sd16;
    t       = y1a - 8'sd16;
    // divide by four, rounding toward zero
    q       = t[7] ? ((t + 8'sd3) >>> 2) : (t >>> 2);
    x1a     = $signed({3'b000, x}) + $signed({{2{ox[5]}}, ox}) + q;
    if (y1a >= cye) begin
      y1b = y1a - 8'sd2;
      x1b = x1a - 8'sd3;
    end else begin
      y1b = y1a + 8'sd2;
      x1b = x1a + 8'sd3;
    end
    oob = (y1b[7:5] != 3'b000) || (x1b[7:5] != 3'b000);
    if (corpse) begin
      skip = in_band || oob;
      src  = {y1b[4:0], x1b[4:0]};
    end else begin
      skip = 1'b0;
      src  = {y, x};
    end
  end

endmodule

[tb/sv/stc_tb_if.sv]
// no extra interfaces needed: the channels come from the rtl interface file
// this file holds the testbench types used by the checker
// depends on stc_pkg
package stc_tb_pkg;
  import stc_pkg::*;

  // one queued read result
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_rgb_t;
endpackage

[tb/sv/stc_checker.sv]
// stc_checker: tile compositor predictor and read-result scoreboard
// depends on stc_pkg, stc_tb_pkg and the rtl channel interfaces
module stc_checker import stc_pkg::*, stc_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  stc_cmd_if.sink     cmd,
  stc_res_if.sink     res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data,
  output int          fail_count,
  output int          pending_reads,
  output int          reads_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [23:0] sprite_mem [NPIX];
  logic [23:0] dest_mem [NPIX];
  bit          drawn [NPIX];
  int          bx_lo, bx_hi, by_lo, by_hi;
  bit          corpse_on;
  logic [1:0]  mesh_sel;
  pixel_rgb_t  read_q [$];

  function automatic int pos(int x, int y);
    return (x + y * 32) & 1023;
  endfunction

  function automatic int band_row(int x);
    if (x < 4 || x >= 28) return 20;
    if (x < 12 || x >= 20) return 19;
    return 18;
  endfunction

  task automatic compose_tile();
    int ox, oy, x, y, x1, y1, cy, src;
    logic [23:0] dd;
    ox = 0;
    oy = 0;
    if (corpse_on) begin
      ox = (bx_hi + bx_lo) / 2 - 16;
      oy = (by_hi + by_lo) / 2 - 16;
    end
    for (y = 0; y < 32; y++) begin
      for (x = 0; x < 32; x++) begin
        src = pos(x, y);
        drawn[src] = 0;
        if (corpse_on) begin
          x1 = x + ox;
          y1 = (y + oy) * 2 - 16;
          cy = band_row(x);
          if (y >= cy - 1 && y <= cy) continue;
          x1 += (y1 - 16) / 4;
          if (y1 >= cy) begin
            y1 -= 2; x1 -= 3;
          end else begin
            y1 += 2; x1 += 3;
          end
          if (x1 < 0 || x1 >= 32 || y1 < 0 || y1 >= 32) continue;
          src = pos(x1, y1);
        end
        dd = sprite_mem[src];
        if (mesh_sel == MESH_DOTS && dd != KEY_RGB && ((x + y) & 1) == 0) dd = '0;
        if (mesh_sel == MESH_CHECKER && (((x / 2) + (y / 2)) & 1) == 1) dd = '0;
        if (dd == KEY_RGB) continue;
        if (corpse_on && dd == '0) continue;
        dest_mem[pos(x, y)] = dd;
        drawn[pos(x, y)] = 1;
      end
    end
    if (corpse_on) begin
      for (x = 0; x < 32; x++) begin
        cy = band_row(x);
        if (drawn[pos(x, cy - 2)] && drawn[pos(x, cy + 1)]) begin
          for (y = cy - 1; y <= cy; y++) begin
            dest_mem[pos(x, y)] = BAND_RGB;
            drawn[pos(x, y)] = 1;
          end
        end
      end
      for (x = 1; x < 32; x++)
        for (y = 1; y < 32; y++)
          if (!drawn[pos(x, y)] && drawn[pos(x - 1, y - 1)]) dest_mem[pos(x, y)] = '0;
      for (x = 3; x < 32; x++)
        for (y = 3; y < 32; y++)
          if (!drawn[pos(x, y)] && !drawn[pos(x - 1, y - 1)]
              && drawn[pos(x - 2, y - 2)] && drawn[pos(x - 3, y - 3)])
            dest_mem[pos(x, y)] = '0;
    end
    bx_lo = 31; bx_hi = 0; by_lo = 31; by_hi = 0;
  endtask

  assign pending_reads = read_q.size();

  always @(posedge clk) begin
    int x, y;
    logic [23:0] s;
    pixel_rgb_t want;
    if (rst) begin
      foreach (drawn[i]) drawn[i] = 0;
      bx_lo = 31; bx_hi = 0; by_lo = 31; by_hi = 0;
      corpse_on = 0;
      mesh_sel = '0;
      fail_count = 0;
      reads_seen = 0;
      read_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CORPSE) corpse_on = cfg_data[0];
        else mesh_sel = cfg_data;
      end
      if (res.valid && res.ready) begin
        reads_seen++;
        if (read_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h%h%h",
                                         res.out_red, res.out_green, res.out_blue);
        end else begin
          want = read_q.pop_front();
          if (want.red !== res.out_red || want.green !== res.out_green
              || want.blue !== res.out_blue) begin
            fail_count++;
            if (fail_count <= 10)
              $display("pixel mismatch: expected %h/%h/%h got %h/%h/%h", want.red,
                       want.green, want.blue, res.out_red, res.out_green, res.out_blue);
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd.func)
          CMD_LOAD: begin
            s = {cmd.sprite_red, cmd.sprite_green, cmd.sprite_blue};
            sprite_mem[cmd.pixel_index] = s;
            dest_mem[cmd.pixel_index] = {cmd.floor_red, cmd.floor_green, cmd.floor_blue};
            x = cmd.pixel_index % 32;
            y = cmd.pixel_index / 32;
            if (s != KEY_RGB && s != '0) begin
              if (x < bx_lo) bx_lo = x;
              if (x > bx_hi) bx_hi = x;
              if (y < by_lo) by_lo = y;
              if (y > by_hi) by_hi = y;
            end
          end
          CMD_COMPOSE: compose_tile();
          CMD_READ: begin
            want = dest_mem[cmd.pixel_index];
            read_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
  end
endmodule

[tb/sv/tb_sprite_tile_compositor.sv]
// tb_sprite_tile_compositor: stimulus and verdict for the sprite tile compositor
// depends on stc_pkg, the channel interfaces, stc_checker and the rtl
module tb_sprite_tile_compositor;
  import stc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 0;
  logic       rst = 1;
  logic       cfg_we = 0;
  logic       cfg_index = CFG_CORPSE;
  logic [1:0] cfg_data = '0;
  int         fail_count, pending_reads, reads_seen;
  int         idle_pct = 0;   // sender gap chance
  int         stall_pct = 0;  // receiver stall chance
  int         loads_done, composes_done, reads_done;

  stc_cmd_if cmd ();
  stc_res_if res ();

  sprite_tile_compositor dut (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .res(res.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stc_checker chk (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .res(res.sink),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_reads(pending_reads), .reads_seen(reads_seen)
  );

  always #5 clk = ~clk;

  // receiver stalls at random according to the phase
  initial res.ready = 0;
  always @(posedge clk) res.ready <= ($urandom_range(99) >= stall_pct);

  initial begin
    cmd.valid = 0;
    cmd.func = CMD_LOAD;
    cmd.pixel_index = '0;
    {cmd.sprite_red, cmd.sprite_green, cmd.sprite_blue} = '0;
    {cmd.floor_red, cmd.floor_green, cmd.floor_blue} = '0;
  end

  // hard stop, well beyond a slow run with every compose in corpse mode
  initial begin
    #50ms;
    $display("FAIL sprite_tile_compositor");
    $finish;
  end

  // one item: optional gap, then hold valid until the handshake
  // valid stays up afterwards; whoever idles the bus drops it
  task automatic send_item(input logic [1:0] f, input logic [9:0] idx,
                           input logic [23:0] spr, input logic [23:0] flr);
    if ($urandom_range(99) < idle_pct) begin
      cmd.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    cmd.valid <= 1;
    cmd.func <= f;
    cmd.pixel_index <= idx;
    {cmd.sprite_red, cmd.sprite_green, cmd.sprite_blue} <= spr;
    {cmd.floor_red, cmd.floor_green, cmd.floor_blue} <= flr;
    do @(posedge clk); while (!cmd.ready);
    case (f)
      CMD_LOAD: loads_done++;
      CMD_COMPOSE: composes_done++;
      CMD_READ: reads_done++;
      default: ;
    endcase
  endtask

  // idle point: all reads back, then room for a compose still running
  task automatic wait_quiet();
    cmd.valid <= 0;
    while (pending_reads != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // random pixel: key, black or a colour, weighted towards real sprites
  function automatic logic [23:0] pick_sprite();
    int r;
    r = $urandom_range(9);
    if (r == 0) return KEY_RGB;
    if (r == 1) return '0;
    return 24'($urandom_range(24'hffffff));
  endfunction

  // one sprite pass: fill a block, compose, read back pixels of the block
  task automatic sprite_round(input int x0, input int y0, input int w, input int h);
    logic [9:0] idx;
    for (int y = y0; y < y0 + h; y++)
      for (int x = x0; x < x0 + w; x++)
        send_item(CMD_LOAD, 10'(x + 32 * y), pick_sprite(),
                  24'($urandom_range(24'hffffff)));
    send_item(CMD_COMPOSE, 10'($urandom), 24'($urandom), 24'($urandom));
    for (int k = 0; k < 16; k++) begin
      idx = 10'((x0 + $urandom_range(w - 1)) + 32 * (y0 + $urandom_range(h - 1)));
      send_item(CMD_READ, idx, 24'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    int modes [4][2];
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // the whole tile gets known floor and sprite values so no read is undefined
    for (int i = 0; i < 1024; i++)
      send_item(CMD_LOAD, 10'(i), (i % 7 == 0) ? KEY_RGB : 24'(i * 40503),
                (i == 0) ? 24'h000000 : 24'hffffff ^ 24'(i));

    // directed: extremes, unused command, colour extremes
    send_item(CMD_READ, 10'd0, '0, '0);
    send_item(CMD_READ, 10'd1023, '1, '1);
    send_item(2'd3, 10'd5, '1, '1);
    send_item(CMD_LOAD, 10'd1023, 24'hffffff, 24'hffffff);
    send_item(CMD_LOAD, 10'd0, 24'h000000, 24'h000000);
    send_item(CMD_COMPOSE, '0, '0, '0);
    send_item(CMD_READ, 10'd1023, '0, '0);
    send_item(CMD_READ, 10'd0, '0, '0);
    wait_quiet();
    write_reg(CFG_CORPSE, 2'd1);
    // empty box in corpse mode, then repeated compose
    send_item(CMD_COMPOSE, '0, '0, '0);
    send_item(CMD_COMPOSE, '0, '0, '0);
    send_item(CMD_READ, 10'd600, '0, '0);
    send_item(CMD_READ, 10'd630, '0, '0);
    wait_quiet();

    // phases over the mode settings, extremes included, mesh 3 among them
    modes = '{'{0, 1}, '{1, 2}, '{0, 3}, '{1, 0}};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_CORPSE, 2'(modes[ph][0]));
      write_reg(CFG_MESH, 2'(modes[ph][1]));
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 54; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 54; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      sprite_round($urandom_range(20), $urandom_range(20), 3 + $urandom_range(5),
                   3 + $urandom_range(5));
      // sender holds off until every read is back
      cmd.valid <= 0;
      do @(posedge clk); while (pending_reads != 0);
      for (int k = 0; k < 12; k++)
        send_item(2'($urandom), 10'($urandom), 24'($urandom), 24'($urandom));
      wait_quiet();
    end

    while (pending_reads != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
    $display("covered %0d loads, %0d composes, %0d reads (%0d results checked)",
             loads_done, composes_done, reads_done, reads_seen);
    $display("modes: corpse on and off, mesh 0 to 3, idle and stall phases");
    if (fail_count == 0 && pending_reads == 0) begin
      $display("PASS sprite_tile_compositor");
    end else begin
      $display("FAIL sprite_tile_compositor");
    end
    $finish;
  end
endmodule
